@@ src/gru_cell_forward_step_defines.svh @@
// assertion macros shared by the gru step rtl
`ifndef GRU_CELL_FORWARD_STEP_DEFINES_SVH
`define GRU_CELL_FORWARD_STEP_DEFINES_SVH

// same-cycle implication, checked on every clock once reset is released
`define GRU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gru step assertion failed");

// next-cycle implication
`define GRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gru step assertion failed");

`endif

@@ src/gru_pkg.sv @@
// shared types, sizes and constants of the gru step block
package gru_pkg;

  // network size
  localparam int FRAME_SIZE  = 16;
  localparam int UNITS       = 16;
  localparam int GATE_SPAN   = FRAME_SIZE * UNITS + UNITS * UNITS + UNITS;
  localparam int STORE_DEPTH = 3 * GATE_SPAN;
  localparam int ADDR_W      = 11;
  localparam int UNIT_W      = $clog2(UNITS);
  localparam int FRM_W       = $clog2(FRAME_SIZE);
  localparam int TERM_W      = $clog2(FRAME_SIZE + UNITS + 1);

  // datapath widths
  localparam int ACC_W  = 40;
  localparam int ACT_W  = 13;
  localparam int GATE_W = 12;
  localparam int MUL_W  = 30;
  localparam int SUM_W  = 31;

  // activation unit sizes
  localparam int EXP_BITS = 15;
  localparam int E_W      = 33;
  localparam int DIV_W    = 47;
  localparam int Q_W      = 12;
  localparam int STEP_W   = 4;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    GATE_R = 2'd0,
    GATE_Z = 2'd1,
    GATE_C = 2'd2
  } gate_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ACT,
    ST_WAIT,
    ST_P1,
    ST_P2,
    ST_P3
  } state_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_EXP,
    AS_SETUP,
    AS_DIV,
    AS_DONE
  } act_state_t;

  // one ring cell: accumulator, hidden value and stored update gate
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [15:0]      h;
    logic [GATE_W-1:0]       g;
  } cell_t;

  // activation request
  typedef struct packed {
    logic start;
    logic tanh_mode;
  } act_ctl_t;

  // exp(-2^i/2048) in q32, worked out at elaboration
  typedef logic [31:0] coef_arr_t [EXP_BITS];

  function automatic coef_arr_t exp_coef_table();
    coef_arr_t t;
    real x;
    for (int i = 0; i < EXP_BITS; i++) begin
      x = $exp(-(2.0 ** i) / 2048.0) * 4294967296.0;
      t[i] = 32'(longint'(x));
    end
    return t;
  endfunction

  localparam coef_arr_t EXP_COEF = exp_coef_table();

endpackage

@@ src/gru_ram.sv @@
// generic single write, single read ram with registered read data
module gru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1584
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/gru_cell.sv @@
// one ring cell holding a unit's accumulator, hidden value and update gate
module gru_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic           clear,
  input  gru_pkg::cell_t prev,
  output gru_pkg::cell_t cur
);
  import gru_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [15:0]      h;
  logic [GATE_W-1:0]       g;

  // hidden value is architectural state, cleared on reset and clear requests
  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else if (clear) begin
      h <= '0;
    end else if (shift) begin
      h <= prev.h;
    end
  end

  // working values move along the ring
  always_ff @(posedge clk) begin
    if (shift) begin
      acc <= prev.acc;
      g   <= prev.g;
    end
  end

  assign cur = '{acc: acc, h: h, g: g};

endmodule

@@ src/gru_act.sv @@
// shared sigmoid / tanh unit: bit-serial exp product then restoring divide
module gru_act (
  input  logic                              clk,
  input  logic                              rst,
  input  gru_pkg::act_ctl_t                 ctl,
  input  logic signed [15:0]                k,
  output logic                              done,
  output logic signed [gru_pkg::ACT_W-1:0] result
);
  import gru_pkg::*;

  act_state_t state, state_next;

  logic                    neg;
  logic                    tmode;
  logic                    sat_hit;
  logic [EXP_BITS-1:0]     m;
  logic [E_W-1:0]          e;
  logic [STEP_W-1:0]       step;
  logic [DIV_W-1:0]        rem;
  logic [DIV_W-1:0]        dvs;
  logic [Q_W-1:0]          q;

  logic signed [16:0]      mag;
  logic [17:0]             mm;
  logic [E_W+31:0]         eprod;
  logic [E_W:0]            dsum;
  logic [E_W-1:0]          nval;
  logic [Q_W-1:0]          p;
  logic signed [ACT_W-1:0] ps;

  // operand magnitude, doubled for tanh
  always_comb begin
    mag   = k[15] ? -(17'(k)) : 17'(k);
    mm    = ctl.tanh_mode ? {mag, 1'b0} : {1'b0, mag};
    eprod = e * EXP_COEF[step];
    dsum  = (E_W + 1)'(E_W'(1) << 32) + (E_W + 1)'(e);
    nval  = tmode ? ((E_W'(1) << 32) - e) : (E_W'(1) << 32);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      AS_IDLE:  if (ctl.start) state_next = AS_EXP;
      AS_EXP:   if (step == STEP_W'(EXP_BITS - 1)) state_next = AS_SETUP;
      AS_SETUP: state_next = AS_DIV;
      AS_DIV:   if (step == STEP_W'(Q_W - 1)) state_next = AS_DONE;
      AS_DONE:  state_next = AS_IDLE;
      default:  state_next = AS_IDLE;
    endcase
  end

  // datapath: one exp factor or one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state)
      AS_IDLE: begin
        if (ctl.start) begin
          neg     <= k[15];
          tmode   <= ctl.tanh_mode;
          sat_hit <= |mm[17:EXP_BITS];
          m       <= mm[EXP_BITS-1:0];
          e       <= E_W'(1) << 32;
          step    <= '0;
        end
      end
      AS_EXP: begin
        if (m[step]) begin
          e <= eprod[E_W+31:32];
        end
        step <= step + 1'b1;
      end
      AS_SETUP: begin
        rem  <= (DIV_W'(nval) << 12) + DIV_W'(dsum);
        dvs  <= DIV_W'(dsum) << 12;
        q    <= '0;
        step <= '0;
      end
      AS_DIV: begin
        if (rem >= dvs) begin
          rem <= rem - dvs;
          q   <= {q[Q_W-2:0], 1'b1};
        end else begin
          q   <= {q[Q_W-2:0], 1'b0};
        end
        dvs  <= dvs >> 1;
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  // sign folding of the rounded magnitude
  always_comb begin
    p  = sat_hit ? Q_W'(2048) : q;
    ps = $signed({1'b0, p});
    if (tmode) begin
      result = neg ? -ps : ps;
    end else begin
      result = neg ? (ACT_W'(2048) - ps) : ps;
    end
    done = (state == AS_DONE);
  end

endmodule

@@ src/gru_cell_forward_step.sv @@
// top level of the gru time step block: sequencer, mac, ring of unit cells
// the final sample of a frame starts a step whose length is set by the one weight ram
// read port feeding one mac and the shared activation unit
// reset clears hidden state, sample count and control; weights need writing
`include "gru_cell_forward_step_defines.svh"

module gru_cell_forward_step (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 kind,
  input  logic [gru_pkg::ADDR_W-1:0] weight_address,
  input  logic signed [15:0]         weight_value,
  input  logic signed [15:0]         sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [3:0]                 unit_index,
  output logic signed [15:0]         hidden_value,
  output logic                       last_of_run
);
  import gru_pkg::*;

  state_t state, state_next;
  gate_t  gate;

  logic [FRM_W-1:0]        elem_cnt;
  logic signed [15:0]      frame [FRAME_SIZE];
  logic signed [15:0]      opnd [UNITS];
  logic [ADDR_W-1:0]       rd_addr;
  logic [TERM_W-1:0]       term;
  logic [UNIT_W-1:0]       unit;

  logic                    s1_v;
  logic                    s1_first;
  logic signed [15:0]      s1_op;
  logic                    s2_v;
  logic                    s2_first;
  logic signed [31:0]      prod;
  logic signed [ACT_W-1:0] act_val;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [SUM_W-1:0] sum;

  logic                    accept;
  logic                    start_step;
  logic                    we;
  logic                    issue;
  logic                    last_issue;
  logic                    unit_last;
  logic                    out_free;
  logic                    z_write;
  logic                    p3_fire;
  logic                    shift;
  logic                    gate_end;
  logic signed [15:0]      operand;
  logic signed [15:0]      rnd_val;
  logic signed [15:0]      rd_data;
  logic signed [ACT_W-1:0] zc;
  logic signed [ACT_W-1:0] zs;

  cell_t    ring [UNITS];
  cell_t    head;
  cell_t    head_next;
  act_ctl_t act_ctl;
  logic     act_done;
  logic signed [ACT_W-1:0] act_res;

  // round half up to q4.11 and saturate to 16 bits
  function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + ACC_W'(1024)) >>> 11;
    if (t > ACC_W'(32767)) begin
      return 16'sh7fff;
    end else if (t < ACC_W'(-32768)) begin
      return -16'sh8000;
    end
    return 16'(t);
  endfunction

  function automatic logic [ADDR_W-1:0] gate_base(input gate_t gs);
    case (gs)
      GATE_Z:  return ADDR_W'(GATE_SPAN);
      GATE_C:  return ADDR_W'(2 * GATE_SPAN);
      default: return '0;
    endcase
  endfunction

  // request decode
  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE);
  assign start_step = accept && (kind == KIND_SAMPLE)
                      && (elem_cnt == FRM_W'(FRAME_SIZE - 1));
  assign we         = accept && (kind == KIND_WEIGHT)
                      && (weight_address < ADDR_W'(STORE_DEPTH));

  // weight store
  gru_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_wram (
    .clk  (clk),
    .we   (we),
    .waddr(weight_address),
    .wdata(weight_value),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // control terms
  always_comb begin
    head       = ring[0];
    issue      = (state == ST_MAC);
    last_issue = issue && (term == TERM_W'(FRAME_SIZE + UNITS))
                 && (unit == UNIT_W'(UNITS - 1));
    unit_last  = (unit == UNIT_W'(UNITS - 1));
    out_free   = !out_valid || !out_stall;
    z_write    = (state == ST_WAIT) && act_done && (gate == GATE_Z);
    p3_fire    = (state == ST_P3) && ((gate != GATE_C) || out_free);
    gate_end   = (z_write || p3_fire) && unit_last;
    shift      = s2_v || z_write || p3_fire;
    rnd_val    = rnd_sat(ACC_W'(sum));
    zc         = $signed({1'b0, GATE_W'(2048) - head.g});
    zs         = $signed({1'b0, head.g});
    act_ctl    = '{start: (state == ST_ACT), tanh_mode: (gate == GATE_C)};
  end

  // mac operand: frame element, recurrent value, or bias scale
  always_comb begin
    if (term < TERM_W'(FRAME_SIZE)) begin
      operand = frame[term[FRM_W-1:0]];
    end else if (term < TERM_W'(FRAME_SIZE + UNITS)) begin
      operand = opnd[UNIT_W'(term - TERM_W'(FRAME_SIZE))];
    end else begin
      operand = 16'sd2048;
    end
  end

  // value entering the tail of the ring
  always_comb begin
    head_next = head;
    if (s2_v) begin
      head_next.acc = s2_first ? ACC_W'(prod) : head.acc + ACC_W'(prod);
    end
    if (z_write) begin
      head_next.g = act_res[GATE_W-1:0];
    end
    if (p3_fire && (gate == GATE_C)) begin
      head_next.h = rnd_val;
    end
  end

  // ring of unit cells
  for (genvar i = 0; i < UNITS; i++) begin : g_ring
    if (i == UNITS - 1) begin : g_tail
      gru_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .clear(accept && (kind == KIND_CLEAR)),
        .prev (head_next),
        .cur  (ring[i])
      );
    end else begin : g_body
      gru_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .clear(accept && (kind == KIND_CLEAR)),
        .prev (ring[i+1]),
        .cur  (ring[i])
      );
    end
  end

  // activation unit
  gru_act u_act (
    .clk   (clk),
    .rst   (rst),
    .ctl   (act_ctl),
    .k     (rnd_sat(head.acc)),
    .done  (act_done),
    .result(act_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start_step) state_next = ST_MAC;
      ST_MAC:   if (last_issue) state_next = ST_DRAIN;
      ST_DRAIN: if (!s1_v && !s2_v) state_next = ST_ACT;
      ST_ACT:   state_next = ST_WAIT;
      ST_WAIT: begin
        if (act_done) begin
          if (gate != GATE_Z) begin
            state_next = ST_P1;
          end else if (unit_last) begin
            state_next = ST_MAC;
          end else begin
            state_next = ST_ACT;
          end
        end
      end
      ST_P1:    state_next = ST_P2;
      ST_P2:    state_next = ST_P3;
      ST_P3: begin
        if (p3_fire) begin
          if (!unit_last) begin
            state_next = ST_ACT;
          end else if (gate == GATE_C) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_MAC;
          end
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer counters and gate order update, reset, candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      if (accept && (kind == KIND_SAMPLE)) begin
        elem_cnt <= (elem_cnt == FRM_W'(FRAME_SIZE - 1)) ? '0 : elem_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start_step) begin
      gate    <= GATE_Z;
      rd_addr <= gate_base(GATE_Z);
      term    <= '0;
      unit    <= '0;
    end else if (issue) begin
      rd_addr <= rd_addr + 1'b1;
      unit    <= unit + 1'b1;
      if (unit_last) begin
        term <= term + 1'b1;
      end
    end else if (z_write || p3_fire) begin
      unit <= unit + 1'b1;
      if (gate_end && (gate != GATE_C)) begin
        gate    <= (gate == GATE_Z) ? GATE_R : GATE_C;
        rd_addr <= gate_base((gate == GATE_Z) ? GATE_R : GATE_C);
        term    <= '0;
      end
    end
  end

  // frame buffer
  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_SAMPLE)) begin
      frame[elem_cnt] <= sample;
    end
  end

  // mac pipeline: operand fetch, then product
  always_ff @(posedge clk) begin
    s1_first <= (term == '0);
    s1_op    <= operand;
    s2_first <= s1_first;
    prod     <= 32'(rd_data) * 32'(s1_op);
  end

  // post-activation arithmetic
  always_ff @(posedge clk) begin
    if (act_done) begin
      act_val <= act_res;
    end
    if (state == ST_P1) begin
      if (gate == GATE_C) begin
        mul_a <= MUL_W'(zc) * MUL_W'(act_val);
      end else begin
        mul_a <= MUL_W'(act_val) * MUL_W'(head.h);
      end
    end
    if (state == ST_P2) begin
      sum <= SUM_W'(mul_a)
             + ((gate == GATE_C) ? SUM_W'(zs) * SUM_W'(head.h) : SUM_W'(0));
    end
  end

  // recurrent operand copy: h, or r*h while the candidate gate runs
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < UNITS; i++) begin
        opnd[i] <= '0;
      end
    end else if (accept && (kind == KIND_CLEAR)) begin
      for (int i = 0; i < UNITS; i++) begin
        opnd[i] <= '0;
      end
    end else if (p3_fire) begin
      opnd[unit] <= rnd_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p3_fire && (gate == GATE_C)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_fire && (gate == GATE_C)) begin
      unit_index   <= 4'(unit);
      hidden_value <= rnd_val;
      last_of_run  <= unit_last;
    end
  end

  // checks
  `GRU_ASSERT_IMPL(a_last_unit, out_valid && last_of_run, unit_index == 4'(UNITS - 1))
  `GRU_ASSERT_IMPL(a_mac_in_step, s2_v, state == ST_MAC || state == ST_DRAIN)
  `GRU_ASSERT_IMPL(a_one_shift, 1'b1, $onehot0({s2_v, z_write, p3_fire}))
  `GRU_ASSERT_NEXT(a_start_busy, state == ST_IDLE && start_step, in_stall)

endmodule

@@ test/gru_step_checker.sv @@
// channel monitor, gru step predictor and hidden value comparison
`timescale 1ns / 1ps

module gru_step_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [10:0]        weight_address,
  input  logic signed [15:0] weight_value,
  input  logic signed [15:0] sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         unit_index,
  input  logic signed [15:0] hidden_value,
  input  logic               last_of_run,
  output int                 fail_count,
  output int                 pending
);
  import gru_pkg::*;

  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  typedef struct {
    logic [3:0]         unit;
    logic signed [15:0] value;
    logic               last;
  } hidden_result_t;

  hidden_result_t expected_hidden[$];

  int weights[STORE_DEPTH];
  int hidden[UNITS];
  int frame[FRAME_SIZE];
  int frame_fill;
  logic [63:0] exp_one;

  // floor(a*b / 2^60)
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // exp(-f) for f in q60, 0..1, alternating series
  function automatic logic [63:0] exp_frac(logic [63:0] f);
    logic [63:0] term;
    logic [63:0] total;
    term = ONE_Q60;
    total = ONE_Q60;
    for (int i = 1; i <= 40; i++) begin
      term = mul_q60(term, f) / i;
      if (term == 0) break;
      if (i % 2 == 1) total = total - term;
      else total = total + term;
    end
    return total;
  endfunction

  // exp(-m/2048) in q60
  function automatic logic [63:0] exp_q60(int m);
    logic [63:0] r;
    r = exp_frac(64'(m & 2047) << 49);
    for (int i = 0; i < (m >> 11); i++) r = mul_q60(r, exp_one);
    return r;
  endfunction

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // round half up to q4.11
  function automatic longint rnd_q11(longint v);
    return (v + 1024) >>> 11;
  endfunction

  function automatic int sigmoid_code(int k);
    logic [63:0] d;
    int p;
    d = (ONE_Q60 + exp_q60(k < 0 ? -k : k)) >> 20;
    p = int'(((64'd1 << 51) + d / 2) / d);
    return k < 0 ? 2048 - p : p;
  endfunction

  function automatic int tanh_code(int k);
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    int p;
    e = exp_q60((k < 0 ? -k : k) * 2);
    num = (ONE_Q60 - e) >> 20;
    den = (ONE_Q60 + e) >> 20;
    p = int'((num * 2048 + den / 2) / den);
    return k < 0 ? -p : p;
  endfunction

  // pre-activation of one gate for one unit
  function automatic int gate_sum(int g, int u, int rec[UNITS]);
    longint acc;
    int base;
    acc = 0;
    base = g * GATE_SPAN;
    for (int j = 0; j < FRAME_SIZE; j++)
      acc += longint'(frame[j]) * weights[base + j * UNITS + u];
    base += FRAME_SIZE * UNITS;
    for (int j = 0; j < UNITS; j++)
      acc += longint'(rec[j]) * weights[base + j * UNITS + u];
    acc += longint'(weights[base + UNITS * UNITS + u]) * 2048;
    return sat16(rnd_q11(acc));
  endfunction

  // one time step: queue the new hidden values in unit order
  task automatic predict_step();
    int h[UNITS];
    int r[UNITS];
    int z[UNITS];
    int rh[UNITS];
    int c;
    hidden_result_t res;
    h = hidden;
    for (int u = 0; u < UNITS; u++) begin
      r[u] = sigmoid_code(gate_sum(0, u, h));
      z[u] = sigmoid_code(gate_sum(1, u, h));
      rh[u] = sat16(rnd_q11(longint'(r[u]) * h[u]));
    end
    for (int u = 0; u < UNITS; u++) begin
      c = tanh_code(gate_sum(2, u, rh));
      hidden[u] = sat16(rnd_q11(longint'(2048 - z[u]) * c + longint'(z[u]) * h[u]));
      res.unit = 4'(u);
      res.value = 16'(hidden[u]);
      res.last = (u == UNITS - 1);
      expected_hidden.push_back(res);
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    frame_fill = 0;
    foreach (weights[i]) weights[i] = 0;
    foreach (hidden[i]) hidden[i] = 0;
    foreach (frame[i]) frame[i] = 0;
    exp_one = exp_frac(ONE_Q60);
  end

  assign pending = expected_hidden.size();

  // requests update the predicted state
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      case (kind)
        KIND_WEIGHT: if (weight_address < STORE_DEPTH) weights[weight_address] = weight_value;
        KIND_SAMPLE: begin
          if (frame_fill >= FRAME_SIZE) frame_fill = 0;
          frame[frame_fill] = sample;
          frame_fill++;
          if (frame_fill == FRAME_SIZE) begin
            frame_fill = 0;
            predict_step();
          end
        end
        KIND_CLEAR: foreach (hidden[i]) hidden[i] = 0;
        default: ;
      endcase
    end
  end

  // results against the oldest expectation
  always @(posedge clk) begin
    hidden_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_hidden.size() == 0) begin
        report("unexpected result, unit", unit_index, 0);
      end else begin
        want = expected_hidden.pop_front();
        if (unit_index !== want.unit) report("unit_index", unit_index, want.unit);
        if (hidden_value !== want.value)
          report("hidden_value", 32'(hidden_value), 32'(want.value));
        if (last_of_run !== want.last) report("last_of_run", last_of_run, want.last);
      end
    end
  end

endmodule

@@ test/testbench.sv @@
// stimulus, clocking and verdict for the gru step block
`timescale 1ns / 1ps

module testbench;
  import gru_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 30000;
  localparam int HOLD_CYCLES = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = KIND_WEIGHT;
  logic [ADDR_W-1:0] weight_address = '0;
  logic signed [15:0] weight_value = '0;
  logic signed [15:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] unit_index;
  logic signed [15:0] hidden_value;
  logic last_of_run;
  int fail_count;
  int pending;

  int burst_left = 0;
  int request_count = 0;
  int idle_cycles = 0;
  logic hold_req = 1'b0;

  always #5 clk = ~clk;

  gru_cell_forward_step dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .weight_address(weight_address), .weight_value(weight_value), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .unit_index(unit_index),
    .hidden_value(hidden_value), .last_of_run(last_of_run)
  );

  gru_step_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .weight_address(weight_address), .weight_value(weight_value), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .unit_index(unit_index),
    .hidden_value(hidden_value), .last_of_run(last_of_run),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stall pattern, mode picked at random per phase, one long hold-off
  always @(posedge clk) begin
    static int mode = 0;
    static int phase = 0;
    static int hold_left = 0;
    static logic hold_done = 1'b0;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (phase == 0) mode = $urandom_range(0, 2);
      phase = (phase + 1) % 50;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (mode == 0) begin
        out_stall <= 1'b0;
      end else if (mode == 1) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // one request, sent in bursts with random gaps
  task automatic send(logic [1:0] k, logic [ADDR_W-1:0] a, logic signed [15:0] w,
                      logic signed [15:0] s);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    weight_address <= a;
    weight_value <= w;
    sample <= s;
    do @(posedge clk); while (in_stall);
    request_count++;
  endtask

  function automatic logic signed [15:0] small_word(int span);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic write_weight(int a, logic signed [15:0] w);
    send(KIND_WEIGHT, ADDR_W'(a), w, 16'($urandom));
  endtask

  task automatic send_sample(logic signed [15:0] s);
    send(KIND_SAMPLE, ADDR_W'($urandom), 16'($urandom), s);
  endtask

  // a whole frame with mostly moderate, sometimes full-range content
  task automatic send_frame();
    logic wide;
    wide = ($urandom_range(0, 4) == 0);
    for (int j = 0; j < FRAME_SIZE; j++)
      send_sample(wide ? 16'($urandom) : small_word(6000));
  endtask

  initial begin
    int pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill every weight word with moderate values
    for (int a = 0; a < STORE_DEPTH; a++) write_weight(a, small_word(300));

    // directed: field extremes, ignored requests, clear, partial frame
    write_weight(0, 16'sh7fff);
    write_weight(STORE_DEPTH - 1, -16'sh8000);
    write_weight(STORE_DEPTH, 16'sh1234);
    write_weight(2047, -16'sh0001);
    send(KIND_UNUSED, '1, '1, '1);
    for (int j = 0; j < FRAME_SIZE; j++) send_sample(j % 2 ? 16'sh7fff : -16'sh8000);
    for (int j = 0; j < FRAME_SIZE; j++) send_sample(16'sh0000);
    send_sample(16'sh0800);
    send(KIND_CLEAR, '0, '0, '0);
    for (int j = 1; j < FRAME_SIZE; j++) send_sample(-16'sh0800);
    write_weight(0, small_word(300));
    write_weight(STORE_DEPTH - 1, small_word(300));

    // sender pause until the block has drained
    in_valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    // random part
    request_count = 0;
    while (request_count < 230) begin
      pick = $urandom_range(0, 99);
      if (request_count > 60 && !hold_req) begin
        hold_req = 1'b1;
        send_frame();
        send_frame();
      end else if (pick < 65) begin
        send_frame();
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 8))
          write_weight($urandom_range(0, STORE_DEPTH - 1),
                       $urandom_range(0, 5) == 0 ? 16'($urandom) : small_word(300));
      end else if (pick < 86) begin
        send(KIND_CLEAR, ADDR_W'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 90) begin
        send(KIND_UNUSED, ADDR_W'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 94) begin
        write_weight($urandom_range(STORE_DEPTH, 2047), 16'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_sample(small_word(6000));
      end
    end

    // drain and verdict
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
